[sv/ocv_soc_interpolator_unit_assert.svh]
// ---------------------------------------------------------------------------
// OCV/SOC interpolator assertion macros
// Concurrent assertion wrappers, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef OCV_SOC_INTERPOLATOR_UNIT_ASSERT_SVH
`define OCV_SOC_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OCV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OCV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ocv_pkg.sv]
// ---------------------------------------------------------------------------
// OCV/SOC interpolator package
// Table constants, reciprocal tables and inter-stage payload types.
// ---------------------------------------------------------------------------
package ocv_pkg;

    localparam int PTS         = 11;
    localparam int SEG_W       = $clog2(PTS);
    localparam int STEP        = 1000;
    localparam int FULL        = 10000;
    localparam int V_LOW       = 2800;
    localparam int V_HIGH      = 4200;
    localparam int RECIP_SHIFT = 20;

    localparam int VIN_W   = 16;
    localparam int CIN_W   = 14;
    localparam int SOC_W   = 14;
    localparam int MV_W    = 13;
    localparam int OPND_W  = 10;
    localparam int NUM_W   = 19;
    localparam int RECIP_W = 15;
    localparam int QUO_W   = 10;
    localparam int BASE_W  = 14;
    localparam int PROD_W  = NUM_W + RECIP_W;

    typedef logic [MV_W-1:0]    mv_t;
    typedef logic [RECIP_W-1:0] recip_t;

    localparam mv_t OCV_MV [PTS] = '{
        13'd2800, 13'd3300, 13'd3520, 13'd3650, 13'd3720, 13'd3780,
        13'd3830, 13'd3890, 13'd3960, 13'd4060, 13'd4200
    };

    // floor(2^20 / span) for each segment span
    localparam recip_t SEG_RECIP [PTS-1] = '{
        15'd2097, 15'd4766, 15'd8065, 15'd14979, 15'd17476,
        15'd20971, 15'd17476, 15'd14979, 15'd10485, 15'd7489
    };

    // floor(2^20 / 1000)
    localparam recip_t STEP_RECIP = 15'd1048;

    typedef enum logic {
        ACT_V2S = 1'b0,
        ACT_S2V = 1'b1
    } act_t;

    typedef struct packed {
        act_t              action;
        logic [OPND_W-1:0] opnd_a;
        logic [OPND_W-1:0] opnd_b;
        logic [OPND_W-1:0] divisor;
        recip_t            recip;
        logic [BASE_W-1:0] base;
    } dec_t;

    typedef struct packed {
        act_t              action;
        logic [NUM_W-1:0]  numer;
        logic [OPND_W-1:0] divisor;
        recip_t            recip;
        logic [BASE_W-1:0] base;
    } prod_t;

    typedef struct packed {
        act_t              action;
        logic [NUM_W-1:0]  numer;
        logic [OPND_W-1:0] divisor;
        logic [QUO_W-1:0]  q_est;
        logic [BASE_W-1:0] base;
    } est_t;

    typedef struct packed {
        act_t              action;
        logic [NUM_W-1:0]  numer;
        logic [OPND_W-1:0] divisor;
        logic [QUO_W-1:0]  q_est;
        logic [NUM_W-1:0]  qd;
        logic [BASE_W-1:0] base;
    } chk_t;

endpackage

[sv/ocv_decode.sv]
// ---------------------------------------------------------------------------
// OCV/SOC segment decode
// Pick the table segment, form multiplier operands, divisor and base.
// ---------------------------------------------------------------------------
module ocv_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [ocv_pkg::VIN_W-1:0]  cell_voltage_mv,
    input  logic [ocv_pkg::CIN_W-1:0]  charge_hundredths,
    output logic                       dec_valid,
    input  logic                       dec_ready,
    output ocv_pkg::dec_t              dec_data
);
    import ocv_pkg::*;

    logic              dec_valid_reg;
    dec_t              dec_data_reg;
    dec_t              dec_next;
    logic [SEG_W-1:0]  seg;
    logic [SEG_W-1:0]  kseg;
    logic              found;
    mv_t               seg_lo;
    mv_t               seg_hi;
    mv_t               k_lo;
    mv_t               k_hi;

    // First segment whose upper point is at or above the voltage
    always_comb
    begin
        seg   = SEG_W'(PTS - 2);
        found = 1'b0;
        for (int i = 0; i < PTS - 1; i++)
        begin
            if (!found && (cell_voltage_mv <= VIN_W'(OCV_MV[i + 1])))
            begin
                seg   = SEG_W'(i);
                found = 1'b1;
            end
        end
    end

    // Charge step index, charge / 1000 below full
    always_comb
    begin
        kseg = '0;
        for (int j = 1; j < PTS - 1; j++)
        begin
            if (charge_hundredths >= CIN_W'(j * STEP))
            begin
                kseg = SEG_W'(j);
            end
        end
    end

    assign seg_lo = OCV_MV[seg];
    assign seg_hi = OCV_MV[seg + SEG_W'(1)];
    assign k_lo   = OCV_MV[kseg];
    assign k_hi   = OCV_MV[kseg + SEG_W'(1)];

    // Clamped cases leave operand a at zero so the quotient drops out
    always_comb
    begin
        dec_next.action  = act_t'(action);
        dec_next.opnd_a  = '0;
        dec_next.opnd_b  = OPND_W'(STEP);
        dec_next.divisor = OPND_W'(STEP);
        dec_next.recip   = STEP_RECIP;
        dec_next.base    = '0;
        if (act_t'(action) == ACT_V2S)
        begin
            priority if (cell_voltage_mv <= VIN_W'(V_LOW))
            begin
                dec_next.base = '0;
            end
            else if (cell_voltage_mv >= VIN_W'(V_HIGH))
            begin
                dec_next.base = BASE_W'(FULL);
            end
            else
            begin
                dec_next.opnd_a  = OPND_W'(cell_voltage_mv - VIN_W'(seg_lo));
                dec_next.divisor = OPND_W'(seg_hi - seg_lo);
                dec_next.recip   = SEG_RECIP[seg];
                dec_next.base    = BASE_W'(int'(seg) * STEP);
            end
        end
        else
        begin
            if (charge_hundredths >= CIN_W'(FULL))
            begin
                dec_next.base = BASE_W'(V_HIGH);
            end
            else
            begin
                dec_next.opnd_a = OPND_W'(charge_hundredths - CIN_W'(int'(kseg) * STEP));
                dec_next.opnd_b = OPND_W'(k_hi - k_lo);
                dec_next.base   = BASE_W'(k_lo);
            end
        end
    end

    assign in_ready = !dec_valid_reg || dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            dec_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dec_data_reg <= dec_next;
        end
    end

    assign dec_valid = dec_valid_reg;
    assign dec_data  = dec_data_reg;

endmodule

[sv/ocv_divide.sv]
// ---------------------------------------------------------------------------
// OCV/SOC multiply and reciprocal divide
// Numerator product, reciprocal quotient estimate, back-multiply.
// ---------------------------------------------------------------------------
module ocv_divide (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           dec_valid,
    output logic           dec_ready,
    input  ocv_pkg::dec_t  dec_data,
    output logic           chk_valid,
    input  logic           chk_ready,
    output ocv_pkg::chk_t  chk_data
);
    import ocv_pkg::*;

    logic                     prod_valid_reg;
    prod_t                    prod_reg;
    prod_t                    prod_next;
    logic                     prod_ready;
    logic                     est_valid_reg;
    est_t                     est_reg;
    est_t                     est_next;
    logic                     est_ready;
    logic                     chk_valid_reg;
    chk_t                     chk_reg;
    chk_t                     chk_next;
    logic [2*OPND_W-1:0]      ab_full;
    logic [PROD_W-1:0]        nr_full;
    logic [QUO_W+OPND_W-1:0]  qd_full;

    // Numerator: a * b
    assign ab_full = dec_data.opnd_a * dec_data.opnd_b;

    always_comb
    begin
        prod_next.action  = dec_data.action;
        prod_next.numer   = ab_full[NUM_W-1:0];
        prod_next.divisor = dec_data.divisor;
        prod_next.recip   = dec_data.recip;
        prod_next.base    = dec_data.base;
    end

    // Quotient estimate: low by at most one
    assign nr_full = prod_reg.numer * prod_reg.recip;

    always_comb
    begin
        est_next.action  = prod_reg.action;
        est_next.numer   = prod_reg.numer;
        est_next.divisor = prod_reg.divisor;
        est_next.q_est   = nr_full[RECIP_SHIFT +: QUO_W];
        est_next.base    = prod_reg.base;
    end

    // Back-multiply for the remainder check
    assign qd_full = est_reg.q_est * est_reg.divisor;

    always_comb
    begin
        chk_next.action  = est_reg.action;
        chk_next.numer   = est_reg.numer;
        chk_next.divisor = est_reg.divisor;
        chk_next.q_est   = est_reg.q_est;
        chk_next.qd      = qd_full[NUM_W-1:0];
        chk_next.base    = est_reg.base;
    end

    assign est_ready  = !chk_valid_reg || chk_ready;
    assign prod_ready = !est_valid_reg || est_ready;
    assign dec_ready  = !prod_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            est_valid_reg  <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end
        else
        begin
            if (dec_ready)
            begin
                prod_valid_reg <= dec_valid;
            end
            if (prod_ready)
            begin
                est_valid_reg <= prod_valid_reg;
            end
            if (est_ready)
            begin
                chk_valid_reg <= est_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_ready && dec_valid)
        begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg)
        begin
            est_reg <= est_next;
        end
        if (est_ready && est_valid_reg)
        begin
            chk_reg <= chk_next;
        end
    end

    assign chk_valid = chk_valid_reg;
    assign chk_data  = chk_reg;

endmodule

[sv/ocv_result.sv]
// ---------------------------------------------------------------------------
// OCV/SOC result stage
// Correct the quotient, add the base and register the result fields.
// ---------------------------------------------------------------------------
module ocv_result (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       chk_valid,
    output logic                       chk_ready,
    input  ocv_pkg::chk_t              chk_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ocv_pkg::SOC_W-1:0]  soc_hundredths,
    output logic [ocv_pkg::MV_W-1:0]   voltage_mv_out
);
    import ocv_pkg::*;

    logic               out_valid_reg;
    logic [SOC_W-1:0]   soc_reg;
    logic [MV_W-1:0]    volt_reg;
    logic [SOC_W-1:0]   soc_next;
    logic [MV_W-1:0]    volt_next;
    logic [NUM_W-1:0]   rem;
    logic [QUO_W-1:0]   quot;
    logic [BASE_W-1:0]  sum;

    assign rem  = chk_data.numer - chk_data.qd;
    assign quot = chk_data.q_est + QUO_W'(rem >= NUM_W'(chk_data.divisor));
    assign sum  = chk_data.base + BASE_W'(quot);

    always_comb
    begin
        unique case (chk_data.action)
            ACT_V2S:
            begin
                soc_next  = SOC_W'(sum);
                volt_next = '0;
            end
            ACT_S2V:
            begin
                soc_next  = '0;
                volt_next = MV_W'(sum);
            end
            default:
            begin
                soc_next  = '0;
                volt_next = '0;
            end
        endcase
    end

    assign chk_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (chk_ready)
        begin
            out_valid_reg <= chk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_ready && chk_valid)
        begin
            soc_reg  <= soc_next;
            volt_reg <= volt_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign soc_hundredths = soc_reg;
    assign voltage_mv_out = volt_reg;

endmodule

[sv/ocv_soc_interpolator_unit.sv]
// ---------------------------------------------------------------------------
// OCV/SOC interpolator: five register stages from input transfer to a valid result.
// Throughput is one transfer per cycle while the output is not stalled, set by the per-stage valid/ready handshake.
// Reset (rst_n low, async) clears all stage valid bits; the payload registers hold no reset.
// ---------------------------------------------------------------------------
`include "ocv_soc_interpolator_unit_assert.svh"

// Piecewise-linear conversion between cell open-circuit voltage and state of
// charge over an 11-point table at 10% steps. Action 0 maps mV to 0.01%,
// action 1 maps 0.01% to mV; the unused result field reads 0.
//
// Pipeline:
//   decode  - segment search by parallel compares, operand and base select
//   divide  - numerator product, reciprocal quotient estimate, back-multiply
//   result  - one-step quotient correction, base add, output register
//
// Each stage advances when its successor can take a transfer, so bubbles
// collapse and a stalled output never blocks stages that are still empty.
module ocv_soc_interpolator_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [ocv_pkg::VIN_W-1:0]  cell_voltage_mv,
    input  logic [ocv_pkg::CIN_W-1:0]  charge_hundredths,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ocv_pkg::SOC_W-1:0]  soc_hundredths,
    output logic [ocv_pkg::MV_W-1:0]   voltage_mv_out
);
    import ocv_pkg::*;

    logic  dec_valid;
    logic  dec_ready;
    dec_t  dec_data;
    logic  chk_valid;
    logic  chk_ready;
    chk_t  chk_data;

    // Stage 1: choose the segment; clamped inputs carry only a base value
    ocv_decode u_decode (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .cell_voltage_mv   (cell_voltage_mv),
        .charge_hundredths (charge_hundredths),
        .dec_valid         (dec_valid),
        .dec_ready         (dec_ready),
        .dec_data          (dec_data)
    );

    // Stages 2-4: numerator, truncated quotient by reciprocal, back-multiply
    ocv_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_data  (dec_data),
        .chk_valid (chk_valid),
        .chk_ready (chk_ready),
        .chk_data  (chk_data)
    );

    // Stage 5: fix up the estimate and hold the result until transfer
    ocv_result u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .chk_valid      (chk_valid),
        .chk_ready      (chk_ready),
        .chk_data       (chk_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .soc_hundredths (soc_hundredths),
        .voltage_mv_out (voltage_mv_out)
    );

    // A free output must open the whole ready chain back to the input
    `OCV_ASSERT_IMP(a_ready_chain, out_ready, in_ready, "ready chain blocked with output free")

    // The reciprocal estimate must be low by at most one
    `OCV_ASSERT_IMP(a_quot_est, chk_valid,
        (chk_data.numer >= chk_data.qd) &&
        ((chk_data.numer - chk_data.qd) < NUM_W'({chk_data.divisor, 1'b0})),
        "quotient estimate off by more than one")

    // Results stay within the table range
    `OCV_ASSERT_IMP(a_out_range, out_valid,
        (soc_hundredths <= SOC_W'(FULL)) && (voltage_mv_out <= MV_W'(V_HIGH)),
        "result outside table range")

endmodule
